// ----- rtl/dlf_pkg.sv -----
// ----------------------------------------------------------------------------
// dlf_pkg: shared definitions for the dense layer forward block
// Widths, field codes, sequencer states and the tanh breakpoint table.
// ----------------------------------------------------------------------------
package dlf_pkg;

	localparam int MAX_IN     = 64;
	localparam int MAX_OUT    = 64;
	localparam int VAL_W      = 16;
	localparam int FRAC_W     = 8;
	localparam int IN_IDX_W   = $clog2(MAX_IN);
	localparam int OUT_IDX_W  = $clog2(MAX_OUT);
	localparam int W_DEPTH    = MAX_IN * MAX_OUT;
	localparam int W_ADDR_W   = IN_IDX_W + OUT_IDX_W;
	localparam int PROD_W     = 2 * VAL_W;
	localparam int ACC_W      = PROD_W + IN_IDX_W;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int KIND_W     = 2;
	localparam int ACT_W      = 2;

	localparam int TANH_ONE    = 256;
	localparam int TANH_SPAN   = 1024;
	localparam int TANH_FRAC_W = 6;
	localparam int TANH_K_W    = 4;
	localparam int TANH_PT_W   = 9;
	localparam int TANH_INT_W  = 2 * TANH_FRAC_W;

	localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INPUT  = 2'd2;

	localparam logic [ACT_W-1:0] ACT_RELU    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LINEAR  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SIGMOID = 2'd2;
	localparam logic [ACT_W-1:0] ACT_TANH    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVATION   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIAS,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_TANH,
		ST_ACT
	} state_t;

	// tanh in Q8.8 at steps of 0.25 from 0 to 4.
	function automatic logic [TANH_PT_W-1:0] tanh_point(input logic [TANH_K_W:0] k);
		logic [TANH_PT_W-1:0] r;
		case (k)
			5'd0:    r = 9'd0;
			5'd1:    r = 9'd63;
			5'd2:    r = 9'd118;
			5'd3:    r = 9'd163;
			5'd4:    r = 9'd195;
			5'd5:    r = 9'd217;
			5'd6:    r = 9'd232;
			5'd7:    r = 9'd241;
			5'd8:    r = 9'd247;
			5'd9:    r = 9'd250;
			5'd10:   r = 9'd253;
			5'd11:   r = 9'd254;
			5'd12:   r = 9'd255;
			5'd13:   r = 9'd255;
			default: r = 9'd256;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/dlf_if.sv -----
// ----------------------------------------------------------------------------
// dlf_if: channel interfaces of the dense layer forward block
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface dlf_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [dlf_pkg::KIND_W-1:0]            kind;
	logic [dlf_pkg::IN_IDX_W-1:0]          row_index;
	logic [dlf_pkg::OUT_IDX_W-1:0]         col_index;
	logic signed [dlf_pkg::VAL_W-1:0]      value;
	logic                                  last_input;

	modport source (output valid, kind, row_index, col_index, value, last_input, input ready);
	modport sink (input valid, kind, row_index, col_index, value, last_input, output ready);
endinterface

interface dlf_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [dlf_pkg::OUT_IDX_W-1:0]         out_index;
	logic signed [dlf_pkg::VAL_W-1:0]      out_value;
	logic                                  out_last;

	modport source (output valid, out_index, out_value, out_last, input ready);
	modport sink (input valid, out_index, out_value, out_last, output ready);
endinterface

interface dlf_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [dlf_pkg::CFG_IDX_W-1:0]         index;
	logic [dlf_pkg::CFG_DATA_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/dense_layer_forward.sv -----
// ----------------------------------------------------------------------------
// dense_layer_forward: fully connected layer with activation
// Stores a kernel, a bias vector and an input vector, and on the last input
// word computes every neuron with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  in_ch    sink       kind, row_index, col_index, value, last_input
//  out_ch   source     out_index, out_value, out_last
//  cfg_ch   sink       index, data (always ready)
//
// A weight, bias or plain input word is stored while idle. A last input word
// starts the sweep: each neuron runs the bias, MAC, drain, scale, tanh and act
// states on the single multiplier, and waits in act while out_ch.ready is low.
// The block takes no input word during the sweep; the last result may still
// be waiting in the output register when the next word is accepted.
// Reset clears control state and sets the registers to 64, 64 and linear.
// ----------------------------------------------------------------------------
module dense_layer_forward (
	input  logic        clk,
	input  logic        arst_n,
	dlf_in_if.sink      in_ch,
	dlf_out_if.source   out_ch,
	dlf_cfg_if.sink     cfg_ch
);

	dlf_pkg::state_t state_q, state_d;

	logic [dlf_pkg::CNT_W-1:0]       in_cnt_q;
	logic [dlf_pkg::CNT_W-1:0]       out_cnt_q;
	logic [dlf_pkg::ACT_W-1:0]       act_q;
	logic [dlf_pkg::IN_IDX_W-1:0]    n_in_m1;
	logic [dlf_pkg::OUT_IDX_W-1:0]   n_out_m1;

	logic [dlf_pkg::IN_IDX_W-1:0]    i_q;
	logic [dlf_pkg::OUT_IDX_W-1:0]   j_q;

	logic signed [dlf_pkg::VAL_W-1:0] w_mem [dlf_pkg::W_DEPTH];
	logic signed [dlf_pkg::VAL_W-1:0] x_mem [dlf_pkg::MAX_IN];
	logic signed [dlf_pkg::VAL_W-1:0] b_mem [dlf_pkg::MAX_OUT];

	logic signed [dlf_pkg::VAL_W-1:0]  bias_rd_q;
	logic signed [dlf_pkg::VAL_W-1:0]  w_rd_s1;
	logic signed [dlf_pkg::VAL_W-1:0]  x_rd_s1;
	logic                              rd_vld_s1;
	logic signed [dlf_pkg::PROD_W-1:0] prod_s2;
	logic                              prod_vld_s2;
	logic signed [dlf_pkg::ACC_W-1:0]  acc_q;

	logic signed [dlf_pkg::ACC_W-1:0]  acc_sh;
	logic signed [dlf_pkg::VAL_W-1:0]  p_sat;
	logic signed [dlf_pkg::VAL_W-1:0]  p_q;

	logic signed [dlf_pkg::VAL_W:0]    p_ext;
	logic [dlf_pkg::VAL_W:0]           mag;
	logic [dlf_pkg::VAL_W:0]           ta;
	logic [dlf_pkg::TANH_K_W-1:0]      tk;
	logic [dlf_pkg::TANH_FRAC_W-1:0]   tf;
	logic [dlf_pkg::TANH_PT_W-1:0]     t_lo;
	logic [dlf_pkg::TANH_PT_W-1:0]     t_hi;
	logic [dlf_pkg::TANH_FRAC_W-1:0]   t_diff;
	logic [dlf_pkg::TANH_PT_W-1:0]     base_q;
	logic [dlf_pkg::TANH_INT_W-1:0]    interp_q;
	logic                              tsat_q;

	logic [dlf_pkg::TANH_PT_W-1:0]     tmag;
	logic signed [dlf_pkg::TANH_PT_W:0]   t_sgn;
	logic signed [dlf_pkg::TANH_PT_W+1:0] sig;
	logic signed [dlf_pkg::VAL_W-1:0]  y;

	logic                              out_valid_q;
	logic [dlf_pkg::OUT_IDX_W-1:0]     out_index_q;
	logic signed [dlf_pkg::VAL_W-1:0]  out_value_q;
	logic                              out_last_q;

	logic in_acc;
	logic start;
	logic issue;
	logic out_free;
	logic out_load;
	logic last_neuron;

	assign in_acc      = in_ch.valid && in_ch.ready;
	assign start       = in_acc && (in_ch.kind == dlf_pkg::KIND_INPUT) && in_ch.last_input;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign last_neuron = (j_q == n_out_m1);
	assign cfg_ch.ready = 1'b1;

	always_comb begin
		if (in_cnt_q == '0) begin
			n_in_m1 = '0;
		end else if (in_cnt_q >= dlf_pkg::CNT_W'(dlf_pkg::MAX_IN)) begin
			n_in_m1 = dlf_pkg::IN_IDX_W'(dlf_pkg::MAX_IN - 1);
		end else begin
			n_in_m1 = dlf_pkg::IN_IDX_W'(in_cnt_q - 1'b1);
		end
		if (out_cnt_q == '0) begin
			n_out_m1 = '0;
		end else if (out_cnt_q >= dlf_pkg::CNT_W'(dlf_pkg::MAX_OUT)) begin
			n_out_m1 = dlf_pkg::OUT_IDX_W'(dlf_pkg::MAX_OUT - 1);
		end else begin
			n_out_m1 = dlf_pkg::OUT_IDX_W'(out_cnt_q - 1'b1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dlf_pkg::ST_IDLE: begin
				if (start) state_d = dlf_pkg::ST_BIAS;
			end
			dlf_pkg::ST_BIAS: state_d = dlf_pkg::ST_MAC;
			dlf_pkg::ST_MAC: begin
				if (i_q == n_in_m1) state_d = dlf_pkg::ST_DRAIN;
			end
			dlf_pkg::ST_DRAIN: begin
				if (!rd_vld_s1 && !prod_vld_s2) state_d = dlf_pkg::ST_SCALE;
			end
			dlf_pkg::ST_SCALE: state_d = dlf_pkg::ST_TANH;
			dlf_pkg::ST_TANH:  state_d = dlf_pkg::ST_ACT;
			dlf_pkg::ST_ACT: begin
				if (out_free) state_d = last_neuron ? dlf_pkg::ST_IDLE : dlf_pkg::ST_BIAS;
			end
			default: state_d = dlf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		issue       = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			dlf_pkg::ST_IDLE: in_ch.ready = 1'b1;
			dlf_pkg::ST_MAC:  issue = 1'b1;
			dlf_pkg::ST_ACT:  out_load = out_free;
			default: begin
				in_ch.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dlf_pkg::ST_IDLE;
			in_cnt_q  <= dlf_pkg::CNT_W'(dlf_pkg::MAX_IN);
			out_cnt_q <= dlf_pkg::CNT_W'(dlf_pkg::MAX_OUT);
			act_q     <= dlf_pkg::ACT_LINEAR;
		end else begin
			state_q <= state_d;
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					dlf_pkg::REG_INPUT_COUNT:  in_cnt_q <= cfg_ch.data;
					dlf_pkg::REG_OUTPUT_COUNT: out_cnt_q <= cfg_ch.data;
					dlf_pkg::REG_ACTIVATION:   act_q <= cfg_ch.data[dlf_pkg::ACT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1   <= issue;
			prod_vld_s2 <= rd_vld_s1;
			if (start) begin
				j_q <= '0;
			end else if (out_load && !last_neuron) begin
				j_q <= j_q + 1'b1;
			end
			if (state_q == dlf_pkg::ST_BIAS) begin
				i_q <= '0;
			end else if (issue) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.kind == dlf_pkg::KIND_WEIGHT) begin
			w_mem[{in_ch.row_index, in_ch.col_index}] <= in_ch.value;
		end
		if (issue) begin
			w_rd_s1 <= w_mem[{i_q, j_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.kind == dlf_pkg::KIND_INPUT) begin
			x_mem[in_ch.row_index] <= in_ch.value;
		end
		if (issue) begin
			x_rd_s1 <= x_mem[i_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.kind == dlf_pkg::KIND_BIAS) begin
			b_mem[in_ch.col_index] <= in_ch.value;
		end
		if (state_q == dlf_pkg::ST_BIAS) begin
			bias_rd_q <= b_mem[j_q];
		end
	end

	// The sum of at most 64 full-range products and the bias stays inside the
	// signed range of the accumulator, so it never overflows.
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prod_s2 <= w_rd_s1 * x_rd_s1;
		end
		if (issue && i_q == '0) begin
			acc_q <= dlf_pkg::ACC_W'(bias_rd_q) <<< dlf_pkg::FRAC_W;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + dlf_pkg::ACC_W'(prod_s2);
		end
	end

	always_comb begin
		acc_sh = acc_q >>> dlf_pkg::FRAC_W;
		if (!acc_sh[dlf_pkg::ACC_W-1] && (|acc_sh[dlf_pkg::ACC_W-2:dlf_pkg::VAL_W-1])) begin
			p_sat = {1'b0, {(dlf_pkg::VAL_W-1){1'b1}}};
		end else if (acc_sh[dlf_pkg::ACC_W-1] && !(&acc_sh[dlf_pkg::ACC_W-2:dlf_pkg::VAL_W-1])) begin
			p_sat = {1'b1, {(dlf_pkg::VAL_W-1){1'b0}}};
		end else begin
			p_sat = acc_sh[dlf_pkg::VAL_W-1:0];
		end
	end

	always_comb begin
		p_ext  = {p_q[dlf_pkg::VAL_W-1], p_q};
		mag    = p_q[dlf_pkg::VAL_W-1] ? unsigned'(-p_ext) : unsigned'(p_ext);
		ta     = (act_q == dlf_pkg::ACT_SIGMOID) ? (mag >> 1) : mag;
		tk     = ta[dlf_pkg::TANH_FRAC_W +: dlf_pkg::TANH_K_W];
		tf     = ta[dlf_pkg::TANH_FRAC_W-1:0];
		t_lo   = dlf_pkg::tanh_point({1'b0, tk});
		t_hi   = dlf_pkg::tanh_point({1'b0, tk} + 1'b1);
		t_diff = dlf_pkg::TANH_FRAC_W'(t_hi - t_lo);
	end

	always_ff @(posedge clk) begin
		if (state_q == dlf_pkg::ST_SCALE) begin
			p_q <= p_sat;
		end
		if (state_q == dlf_pkg::ST_TANH) begin
			base_q   <= t_lo;
			interp_q <= (t_diff * tf) + dlf_pkg::TANH_INT_W'(dlf_pkg::TANH_ONE / 8);
			tsat_q   <= (ta >= (dlf_pkg::VAL_W+1)'(dlf_pkg::TANH_SPAN));
		end
	end

	always_comb begin
		tmag  = tsat_q ? dlf_pkg::TANH_PT_W'(dlf_pkg::TANH_ONE)
			: base_q + dlf_pkg::TANH_PT_W'(interp_q >> dlf_pkg::TANH_FRAC_W);
		t_sgn = p_q[dlf_pkg::VAL_W-1] ? -signed'({1'b0, tmag}) : signed'({1'b0, tmag});
		sig   = ((dlf_pkg::TANH_PT_W+2)'(dlf_pkg::TANH_ONE + 1) + (dlf_pkg::TANH_PT_W+2)'(t_sgn))
			>>> 1;
		case (act_q)
			dlf_pkg::ACT_RELU:    y = p_q[dlf_pkg::VAL_W-1] ? '0 : p_q;
			dlf_pkg::ACT_LINEAR:  y = p_q;
			dlf_pkg::ACT_SIGMOID: y = dlf_pkg::VAL_W'(sig);
			dlf_pkg::ACT_TANH:    y = dlf_pkg::VAL_W'(t_sgn);
			default:              y = p_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_index_q <= j_q;
			out_value_q <= y;
			out_last_q  <= last_neuron;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_index = out_index_q;
	assign out_ch.out_value = out_value_q;
	assign out_ch.out_last  = out_last_q;

endmodule

// ----- verif/dense_layer_forward_test.sv -----
// ----------------------------------------------------------------------------
// dense_layer_forward_test: self-checking bench for the dense layer block
// Loads kernels, biases and input vectors, runs every activation under
// several count settings and checks each neuron result field by field
// against a fixed-point model of the layer, with random idling on the input and result channels.
// ----------------------------------------------------------------------------
module dense_layer_forward_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dlf_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 4000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int IDLE_PERCENT  = 32;
	localparam int REPORT_LINES  = 40;
	localparam int PHASE_COUNT   = 7;
	localparam int PHASE_WORDS   = 10;

	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic [IN_IDX_W-1:0]     row;
		logic [OUT_IDX_W-1:0]    col;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} layer_word_t;

	typedef struct {
		logic [OUT_IDX_W-1:0]    index;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} neuron_result_t;

	typedef struct {
		logic [ACT_W-1:0]        act;
		layer_word_t             word;
		bit                      has_want;
		logic signed [VAL_W-1:0] want;
	} directed_row_t;

	logic clk;
	logic arst_n;

	dlf_in_if  in_ch();
	dlf_out_if out_ch();
	dlf_cfg_if cfg_ch();

	dense_layer_forward uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	logic signed [VAL_W-1:0] weight_q [MAX_IN][MAX_OUT];
	bit                      weight_set [MAX_IN][MAX_OUT];
	logic signed [VAL_W-1:0] bias_q [MAX_OUT];
	bit                      bias_set [MAX_OUT];
	logic signed [VAL_W-1:0] input_q [MAX_IN];
	bit                      input_set [MAX_IN];
	logic [CNT_W-1:0]        inputs_in_use;
	logic [CNT_W-1:0]        outputs_in_use;
	logic [ACT_W-1:0]        act_mode;

	neuron_result_t expected_neurons[$];
	directed_row_t  directed_rows[$];

	int cycle_count = 0;
	int error_count = 0;
	int words_accepted = 0;
	int results_checked = 0;
	int settings_used = 0;
	bit no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("dense_layer_forward: mismatch");
		$finish;
	end

	function automatic int clamp_count(logic [CNT_W-1:0] c, int top);
		if (c == 0)
			return 1;
		if (c > top)
			return top;
		return int'(c);
	endfunction

	function automatic int tanh_step(int k);
		case (k)
			0:       return 0;
			1:       return 63;
			2:       return 118;
			3:       return 163;
			4:       return 195;
			5:       return 217;
			6:       return 232;
			7:       return 241;
			8:       return 247;
			9:       return 250;
			10:      return 253;
			11:      return 254;
			12:      return 255;
			13:      return 255;
			default: return 256;
		endcase
	endfunction

	function automatic int tanh_magnitude(int a);
		int k;
		int f;
		if (a >= 1024)
			return 256;
		k = a >>> 6;
		f = a & 63;
		return tanh_step(k) + (((tanh_step(k + 1) - tanh_step(k)) * f + 32) >>> 6);
	endfunction

	function automatic longint saturate_q88(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint activate_q88(longint p, logic [ACT_W-1:0] mode);
		int a;
		int t;
		a = (p < 0) ? int'(-p) : int'(p);
		case (mode)
			ACT_RELU: begin
				return (p < 0) ? 0 : p;
			end
			ACT_LINEAR: begin
				return p;
			end
			ACT_SIGMOID: begin
				t = tanh_magnitude(a >>> 1);
				if (p < 0)
					t = -t;
				return longint'((256 + t + 1) >>> 1);
			end
			default: begin
				t = tanh_magnitude(a);
				return (p < 0) ? longint'(-t) : longint'(t);
			end
		endcase
	endfunction

	function automatic void predict_layer();
		int n_in;
		int n_out;
		int i;
		int j;
		longint acc;
		neuron_result_t r;
		n_in = clamp_count(inputs_in_use, MAX_IN);
		n_out = clamp_count(outputs_in_use, MAX_OUT);
		for (j = 0; j < n_out; j++) begin
			acc = longint'(bias_q[j]) <<< FRAC_W;
			for (i = 0; i < n_in; i++)
				acc = acc + longint'(weight_q[i][j]) * longint'(input_q[i]);
			r.index = OUT_IDX_W'(j);
			r.value = VAL_W'(saturate_q88(activate_q88(saturate_q88(acc >>> FRAC_W), act_mode)));
			r.last = (j == n_out - 1);
			expected_neurons.push_back(r);
		end
	endfunction

	function automatic void apply_word(layer_word_t w);
		case (w.kind)
			KIND_WEIGHT: begin
				weight_q[w.row][w.col] = w.value;
				weight_set[w.row][w.col] = 1'b1;
			end
			KIND_BIAS: begin
				bias_q[w.col] = w.value;
				bias_set[w.col] = 1'b1;
			end
			KIND_INPUT: begin
				input_q[w.row] = w.value;
				input_set[w.row] = 1'b1;
				if (w.last)
					predict_layer();
			end
			default: ;
		endcase
		if (w.kind != KIND_UNUSED)
			words_accepted++;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= REPORT_LINES)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_neuron();
		neuron_result_t want;
		if (expected_neurons.size() == 0) begin
			report_mismatch($sformatf("result index %0d value %0d arrived with none pending",
				out_ch.out_index, out_ch.out_value));
		end else begin
			want = expected_neurons.pop_front();
			results_checked++;
			if (out_ch.out_index !== want.index || out_ch.out_value !== want.value ||
					out_ch.out_last !== want.last)
				report_mismatch($sformatf("got index %0d value %0d last %0b, want %0d %0d %0b",
					out_ch.out_index, out_ch.out_value, out_ch.out_last,
					want.index, want.value, want.last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			check_neuron();
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	task automatic send_word(layer_word_t w);
		int gap;
		gap = 0;
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
			gap++;
		@(negedge clk);
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= w.kind;
		in_ch.row_index <= w.row;
		in_ch.col_index <= w.col;
		in_ch.value <= w.value;
		in_ch.last_input <= w.last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		apply_word(w);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_DATA_W'(data);
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			REG_INPUT_COUNT:  inputs_in_use = CNT_W'(data);
			REG_OUTPUT_COUNT: outputs_in_use = CNT_W'(data);
			REG_ACTIVATION:   act_mode = ACT_W'(data);
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_neurons.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(logic [ACT_W-1:0] act, logic [KIND_W-1:0] kind, int row, int col,
			int value, bit last, bit has_want, int want);
		directed_row_t r;
		r.act = act;
		r.word.kind = kind;
		r.word.row = IN_IDX_W'(row);
		r.word.col = OUT_IDX_W'(col);
		r.word.value = VAL_W'(value);
		r.word.last = last;
		r.has_want = has_want;
		r.want = VAL_W'(want);
		directed_rows.push_back(r);
	endtask

	function automatic logic signed [VAL_W-1:0] draw_value();
		int v;
		v = $urandom_range(512);
		case ($urandom_range(9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3:    return VAL_W'($urandom);
			default: return VAL_W'(v - 256);
		endcase
	endfunction

	function automatic int pick_index(int n, int top);
		if ($urandom_range(99) < 70)
			return $urandom_range(n - 1);
		return $urandom_range(top - 1);
	endfunction

	function automatic layer_word_t random_word(int n_in, int n_out);
		layer_word_t w;
		w.row = IN_IDX_W'(pick_index(n_in, MAX_IN));
		w.col = OUT_IDX_W'(pick_index(n_out, MAX_OUT));
		w.value = draw_value();
		w.last = 1'b0;
		case ($urandom_range(9))
			0, 1, 2, 3: w.kind = KIND_WEIGHT;
			4, 5:       w.kind = KIND_BIAS;
			6, 7:       w.kind = KIND_INPUT;
			8: begin
				w.kind = KIND_UNUSED;
				w.last = $urandom_range(1);
			end
			default: begin
				w.kind = $urandom_range(1) ? KIND_WEIGHT : KIND_BIAS;
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

	task automatic fill_gaps(int n_in, int n_out, int skip_row);
		layer_word_t w;
		int i;
		int j;
		w.last = 1'b0;
		for (j = 0; j < n_out; j++) begin
			if (!bias_set[j]) begin
				w.kind = KIND_BIAS;
				w.row = IN_IDX_W'($urandom);
				w.col = OUT_IDX_W'(j);
				w.value = draw_value();
				send_word(w);
			end
			for (i = 0; i < n_in; i++) begin
				if (!weight_set[i][j]) begin
					w.kind = KIND_WEIGHT;
					w.row = IN_IDX_W'(i);
					w.col = OUT_IDX_W'(j);
					w.value = draw_value();
					send_word(w);
				end
			end
		end
		for (i = 0; i < n_in; i++) begin
			if (!input_set[i] && i != skip_row) begin
				w.kind = KIND_INPUT;
				w.row = IN_IDX_W'(i);
				w.col = OUT_IDX_W'($urandom);
				w.value = draw_value();
				send_word(w);
			end
		end
	endtask

	task automatic run_vector(int n_in, int n_out);
		layer_word_t w;
		int writes;
		int last_row;
		writes = $urandom_range(1, 6);
		repeat (writes) send_word(random_word(n_in, n_out));
		last_row = pick_index(n_in, MAX_IN);
		fill_gaps(n_in, n_out, last_row);
		w.kind = KIND_INPUT;
		w.row = IN_IDX_W'(last_row);
		w.col = OUT_IDX_W'($urandom);
		w.value = draw_value();
		w.last = 1'b1;
		send_word(w);
	endtask

	initial begin
		int cin;
		int cout;
		logic [ACT_W-1:0] act;
		int n_in;
		int n_out;
		int start_words;
		int vectors;
		neuron_result_t typed;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_WEIGHT;
		in_ch.row_index = '0;
		in_ch.col_index = '0;
		in_ch.value = '0;
		in_ch.last_input = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_INPUT_COUNT;
		cfg_ch.data = '0;
		inputs_in_use = CNT_W'(MAX_IN);
		outputs_in_use = CNT_W'(MAX_OUT);
		act_mode = ACT_LINEAR;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		cfg_write(REG_INPUT_COUNT, 1);
		cfg_write(REG_OUTPUT_COUNT, 1);
		settings_used++;

		add_row(ACT_LINEAR,  KIND_WEIGHT, 0, 0, 256, 0, 0, 0);
		add_row(ACT_LINEAR,  KIND_BIAS, 0, 0, 0, 0, 0, 0);
		add_row(ACT_LINEAR,  KIND_WEIGHT, 63, 63, -32768, 0, 0, 0);
		add_row(ACT_LINEAR,  KIND_INPUT, 63, 63, 32767, 0, 0, 0);
		add_row(ACT_LINEAR,  KIND_INPUT, 0, 0, 32767, 1, 1, 32767);
		add_row(ACT_LINEAR,  KIND_INPUT, 0, 0, -32768, 1, 1, -32768);
		add_row(ACT_LINEAR,  KIND_INPUT, 0, 0, 0, 1, 1, 0);
		add_row(ACT_LINEAR,  KIND_UNUSED, 63, 63, -1, 1, 0, 0);
		add_row(ACT_LINEAR,  KIND_WEIGHT, 0, 0, 32767, 1, 0, 0);
		add_row(ACT_LINEAR,  KIND_INPUT, 0, 0, 32767, 1, 1, 32767);
		add_row(ACT_LINEAR,  KIND_INPUT, 0, 0, -32768, 1, 1, -32768);
		add_row(ACT_RELU,    KIND_INPUT, 0, 0, -32768, 1, 1, 0);
		add_row(ACT_RELU,    KIND_INPUT, 0, 0, 32767, 1, 1, 32767);
		add_row(ACT_SIGMOID, KIND_INPUT, 0, 0, 32767, 1, 1, 256);
		add_row(ACT_SIGMOID, KIND_INPUT, 0, 0, -32768, 1, 1, 0);
		add_row(ACT_TANH,    KIND_INPUT, 0, 0, 32767, 1, 1, 256);
		add_row(ACT_TANH,    KIND_INPUT, 0, 0, -32768, 1, 1, -256);
		add_row(ACT_LINEAR,  KIND_BIAS, 0, 0, 32767, 0, 0, 0);
		add_row(ACT_LINEAR,  KIND_WEIGHT, 0, 0, 0, 0, 0, 0);
		add_row(ACT_LINEAR,  KIND_INPUT, 0, 0, 4660, 1, 1, 32767);
		add_row(ACT_LINEAR,  KIND_BIAS, 0, 0, -32768, 0, 0, 0);
		add_row(ACT_LINEAR,  KIND_INPUT, 0, 0, 100, 1, 1, -32768);
		add_row(ACT_LINEAR,  KIND_BIAS, 0, 0, 0, 0, 0, 0);
		add_row(ACT_LINEAR,  KIND_WEIGHT, 0, 0, 256, 0, 0, 0);
		add_row(ACT_SIGMOID, KIND_INPUT, 0, 0, 0, 1, 1, 128);
		add_row(ACT_TANH,    KIND_INPUT, 0, 0, 256, 1, 1, 195);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].act != act_mode) begin
				settle();
				cfg_write(REG_ACTIVATION, int'(directed_rows[r].act));
			end
			send_word(directed_rows[r].word);
			if (directed_rows[r].has_want) begin
				typed = expected_neurons.pop_back();
				typed.value = directed_rows[r].want;
				expected_neurons.push_back(typed);
			end
		end

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: begin
					cin = 0;
					cout = 3;
					act = ACT_RELU;
				end
				1: begin
					cin = 127;
					cout = 1;
					act = ACT_TANH;
				end
				2: begin
					cin = 64;
					cout = 1;
					act = ACT_SIGMOID;
				end
				3: begin
					cin = 3;
					cout = 4;
					act = ACT_LINEAR;
				end
				4: begin
					cin = 6;
					cout = 0;
					act = ACT_TANH;
				end
				5: begin
					cin = 1;
					cout = 8;
					act = ACT_SIGMOID;
				end
				default: begin
					cin = $urandom_range(1, 4);
					cout = $urandom_range(1, 4);
					act = ACT_W'($urandom_range(3));
				end
			endcase
			settle();
			no_idle = (ph == 5);
			cfg_write(REG_INPUT_COUNT, cin);
			cfg_write(REG_OUTPUT_COUNT, cout);
			cfg_write(REG_ACTIVATION, int'(act));
			settings_used++;
			n_in = clamp_count(inputs_in_use, MAX_IN);
			n_out = clamp_count(outputs_in_use, MAX_OUT);
			start_words = words_accepted;
			vectors = 0;
			while (words_accepted - start_words < PHASE_WORDS || vectors < 2) begin
				run_vector(n_in, n_out);
				vectors++;
			end
		end
		no_idle = 1'b0;
		settle();

		$display("Run covered %0d accepted words and %0d neuron results over %0d settings,",
			words_accepted, results_checked, settings_used);
		$display("with all four activations, count extremes and saturating values.");
		if (error_count == 0)
			$display("dense_layer_forward: match");
		else
			$display("dense_layer_forward: mismatch");
		$finish;
	end

endmodule
